/* src/lru_pkg.sv */
package lru_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned KeyW = 31;
  localparam int unsigned ValW = 64;
  localparam int unsigned CapW = 5;
  localparam int unsigned OccW = 5;
  localparam int unsigned LimW = (CntW > CapW) ? CntW : CapW;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  localparam logic KindGet = 1'b0;
  localparam logic KindPut = 1'b1;

  typedef struct packed {
    logic            hit;
    logic            ins;
    logic [IdxW-1:0] idx;
    logic [CntW-1:0] count;
  } lru_dec_t;

endpackage

/* src/lru_cfg_if.sv */
interface lru_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lru_pkg::CapW-1:0]  data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

/* src/lru_req_if.sv */
interface lru_req_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [lru_pkg::KeyW-1:0]  key;
  logic [lru_pkg::ValW-1:0]  value_in;

  modport source(output valid, kind, key, value_in, input ready);
  modport sink(input valid, kind, key, value_in, output ready);
endinterface

/* src/lru_rsp_if.sv */
interface lru_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [lru_pkg::ValW-1:0]  value_out;
  logic [lru_pkg::OccW-1:0]  occupancy;

  modport source(output valid, hit, value_out, occupancy, input ready);
  modport sink(input valid, hit, value_out, occupancy, output ready);
endinterface

/* src/lru_tags.sv */
module lru_tags (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      lookup_i,
  input  logic                      kind_i,
  input  logic [lru_pkg::KeyW-1:0]  key_i,
  input  logic [lru_pkg::LimW-1:0]  limit_i,
  output lru_pkg::lru_dec_t         dec_o
);
  import lru_pkg::*;

  logic [ENTRIES-1:0][KeyW-1:0] key_q;
  logic [ENTRIES-1:0]           valid_q, valid_d;
  logic [ENTRIES-1:0][IdxW-1:0] rank_q, rank_d;
  logic [CntW-1:0]              count_q, count_d;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] evict_oh;
  logic [ENTRIES-1:0] avail;
  logic               hit;
  logic               full;
  logic               ins;
  logic               evict;
  logic [IdxW-1:0]    hit_idx;
  logic [IdxW-1:0]    slot;
  logic [IdxW-1:0]    hit_rank;
  logic [CntW-1:0]    oldest;

  always_comb begin
    match    = '0;
    evict_oh = '0;
    hit_idx  = '0;
    slot     = '0;
    oldest   = count_q - CntW'(1);
    full     = LimW'(count_q) >= limit_i;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (key_q[i] == key_i);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IdxW'(i);
      end
    end
    hit = |match;
    ins = !hit && (kind_i == KindPut) && (limit_i != '0);
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (full && valid_q[i] && (CntW'(rank_q[i]) == oldest)) begin
        evict_oh    = '0;
        evict_oh[i] = 1'b1;
      end
    end
    evict = |evict_oh;
    avail = ~valid_q | evict_oh;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (avail[i]) begin
        slot = IdxW'(i);
      end
    end
    hit_rank = rank_q[hit_idx];
  end

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    count_d = count_q;
    if (hit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_d[i] = rank_q[i] + IdxW'(1);
        end
      end
      rank_d[hit_idx] = '0;
    end else if (ins) begin
      valid_d = valid_q & ~evict_oh;
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_d[i]) begin
          rank_d[i] = rank_q[i] + IdxW'(1);
        end
      end
      rank_d[slot]  = '0;
      valid_d[slot] = 1'b1;
      if (!evict) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  assign dec_o.hit   = hit;
  assign dec_o.ins   = ins;
  assign dec_o.idx   = hit ? hit_idx : slot;
  assign dec_o.count = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rank_q  <= '0;
      count_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (lookup_i) begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lookup_i && ins) begin
      key_q[slot] <= key_i;
    end
  end

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("entry count disagrees with the valid bits");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ENTRIES))
    else $error("entry count exceeds the number of entries");

  a_insert_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_i && !clear_i && dec_o.ins |=> valid_q[$past(dec_o.idx)])
    else $error("inserted entry is not valid");

endmodule

/* src/lru_key_value_cache.sv */
// Each request passes through a lookup state and a response state: the
// result is registered into the output in the response state once the
// output is free, and a new request is taken only in the idle state or
// in the response state with the output free. The value memory is read in the lookup state.
// Reset empties the cache and sets the capacity to 16; a capacity write
// empties it as well.
module lru_key_value_cache (
  input  logic       clk_i,
  input  logic       rst_ni,
  lru_cfg_if.sink    cfg_i,
  lru_req_if.sink    req_i,
  lru_rsp_if.source  rsp_o
);
  import lru_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLook = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CapW-1:0] cap_q;
  logic            kind_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;
  logic            hit_q;
  logic [OccW-1:0] occ_q;
  logic [ValW-1:0] rdata_q;
  logic            rsp_valid_q;
  logic            rsp_hit_q;
  logic [ValW-1:0] rsp_val_q;
  logic [OccW-1:0] rsp_occ_q;

  logic [ValW-1:0] mem [ENTRIES];

  logic            cfg_xfer;
  logic            req_xfer;
  logic            lookup;
  logic            out_free;
  logic            load_rsp;
  logic [LimW-1:0] limit;
  lru_dec_t        dec;

  assign cfg_i.ready = 1'b1;
  assign cfg_xfer    = cfg_i.valid && cfg_i.ready;

  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == StIdle) || ((state_q == StDone) && out_free);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign lookup      = state_q == StLook;
  assign load_rsp    = (state_q == StDone) && out_free;

  assign limit = (LimW'(cap_q) > LimW'(ENTRIES)) ? LimW'(ENTRIES) : LimW'(cap_q);

  lru_tags u_tags (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (cfg_xfer),
    .lookup_i (lookup),
    .kind_i   (kind_q),
    .key_i    (key_q),
    .limit_i  (limit),
    .dec_o    (dec)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (req_xfer) begin
          state_d = StLook;
        end
      end
      StLook: begin
        state_d = StDone;
      end
      StDone: begin
        if (out_free) begin
          state_d = req_xfer ? StLook : StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cap_q       <= CapReset;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_xfer) begin
        cap_q <= cfg_i.data;
      end
      if (load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      kind_q <= req_i.kind;
      key_q  <= req_i.key;
      val_q  <= req_i.value_in;
    end
    if (lookup) begin
      hit_q <= dec.hit;
      occ_q <= OccW'(dec.count);
    end
    if (load_rsp) begin
      rsp_hit_q <= hit_q;
      rsp_val_q <= (hit_q && (kind_q == KindGet)) ? rdata_q : '0;
      rsp_occ_q <= occ_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lookup) begin
      if ((kind_q == KindPut) && (dec.hit || dec.ins)) begin
        mem[dec.idx] <= val_q;
      end
      rdata_q <= mem[dec.idx];
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.hit       = rsp_hit_q;
  assign rsp_o.value_out = rsp_val_q;
  assign rsp_o.occupancy = rsp_occ_q;

  a_look_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLook |=> state_q == StDone)
    else $error("lookup not followed by the response cycle");

  a_value_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.value_out != '0) |-> rsp_o.hit)
    else $error("nonzero value reported without a hit");

  a_rsp_loaded_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == StDone)
    else $error("response raised outside the response cycle");

endmodule
